FILE: hdl/fra_pkg.sv
// Shared types and constants for the slot-handle allocator.
// No dependencies; every module of the allocator imports this package.
`default_nettype none

package fra_pkg;

    localparam int NUM_SLOTS = 256;
    localparam int MAP_DEPTH = 256;
    localparam int HANDLE_W  = 8;
    localparam int COUNT_W   = 9;
    // Handles are eight bits wide, so the usable pool is capped at the map depth.
    localparam int CAPACITY  = (NUM_SLOTS > MAP_DEPTH) ? MAP_DEPTH : NUM_SLOTS;

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_TRY   = 2'd1,
        FUNC_FREE  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NONE      = 2'd1,
        STATUS_NOT_ALLOC = 2'd2,
        STATUS_EXHAUSTED = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic    rd_en;
        handle_t rd_addr;
        logic    wr_en;
        handle_t wr_addr;
        logic    wr_data;
    } map_req_t;

    typedef struct packed {
        logic    rd_en;
        handle_t rd_addr;
        logic    wr_en;
        handle_t wr_addr;
        handle_t wr_data;
    } queue_req_t;

endpackage

`default_nettype wire

FILE: hdl/fifo_reuse_slot_allocator_unit.sv
// Slot-handle allocator with a FIFO free list; top level, uses fra_pkg and both stores.
// Flow: the bitmap and queue memories are read at the accept edge, and the execute
// state writes back and registers the result item. No new request is taken until
// that commit; a result item left waiting holds the next request in its execute
// state until the result is taken.
`default_nettype none

module fifo_reuse_slot_allocator_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire logic [1:0] func,
    input  wire logic [7:0] handle,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output logic [7:0]      out_handle,
    output logic            granted,
    output logic [1:0]      status
);
    import fra_pkg::*;

    // Control state.
    state_t  state_reg, state_next;
    handle_t queue_head_reg, queue_head_next;
    count_t  queue_count_reg, queue_count_next;
    count_t  fresh_next_reg, fresh_next_next;

    // The request is held here while its memory reads are in flight.
    logic [1:0] func_reg;
    handle_t    handle_reg;

    // Result register, which separates the response side from the request side.
    logic    rsp_valid_reg, rsp_valid_next;
    handle_t out_handle_reg, out_handle_next;
    logic    granted_reg, granted_next;
    status_t status_reg, status_next;

    logic       req_fire;
    logic       exec_fire;
    logic       map_bit;
    handle_t    queue_data;
    map_req_t   map_req;
    queue_req_t queue_req;

    fra_map_store u_map_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .map_req (map_req),
        .rd_data (map_bit)
    );

    fra_queue_store u_queue_store (
        .clk       (clk),
        .queue_req (queue_req),
        .rd_data   (queue_data)
    );

    // Next-state logic. A request is taken in idle even when the previous
    // result is still waiting; the execute cycle then waits for the result
    // register to drain before it commits.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // FSM outputs.
    always_comb
    begin
        req_ready = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_EXEC:
            begin
                exec_fire = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign req_fire = req_valid && req_ready;

    // Both memories are read at the accept edge: the bitmap at the handle to
    // be freed and the queue at its head. Since a request commits its writes
    // before the next one is accepted, reads never race a pending write.
    always_comb
    begin
        map_req           = '0;
        queue_req         = '0;
        map_req.rd_en     = req_fire;
        map_req.rd_addr   = handle;
        queue_req.rd_en   = req_fire;
        queue_req.rd_addr = queue_head_reg;

        queue_head_next  = queue_head_reg;
        queue_count_next = queue_count_reg;
        fresh_next_next  = fresh_next_reg;
        out_handle_next  = '0;
        granted_next     = 1'b0;
        status_next      = STATUS_OK;

        unique case (func_reg)
            FUNC_ALLOC, FUNC_TRY:
            begin
                if (queue_count_reg != '0)
                begin
                    // Oldest freed handle is reused first.
                    out_handle_next  = queue_data;
                    granted_next     = 1'b1;
                    queue_head_next  = queue_head_reg + 1'b1;
                    queue_count_next = queue_count_reg - 1'b1;
                    map_req.wr_en    = exec_fire;
                    map_req.wr_addr  = queue_data;
                    map_req.wr_data  = 1'b1;
                end
                else if (func_reg == FUNC_TRY)
                begin
                    // A try never draws from the fresh counter.
                    status_next = STATUS_NONE;
                end
                else if (fresh_next_reg >= COUNT_W'(CAPACITY))
                begin
                    status_next = STATUS_EXHAUSTED;
                end
                else
                begin
                    out_handle_next = fresh_next_reg[HANDLE_W-1:0];
                    granted_next    = 1'b1;
                    fresh_next_next = fresh_next_reg + 1'b1;
                    map_req.wr_en   = exec_fire;
                    map_req.wr_addr = fresh_next_reg[HANDLE_W-1:0];
                    map_req.wr_data = 1'b1;
                end
            end
            FUNC_FREE:
            begin
                if (!map_bit)
                begin
                    status_next = STATUS_NOT_ALLOC;
                end
                else
                begin
                    // Clear the bit and append the handle at the queue tail.
                    map_req.wr_en     = exec_fire;
                    map_req.wr_addr   = handle_reg;
                    map_req.wr_data   = 1'b0;
                    queue_req.wr_en   = exec_fire;
                    queue_req.wr_addr = queue_head_reg + queue_count_reg[HANDLE_W-1:0];
                    queue_req.wr_data = handle_reg;
                    queue_count_next  = queue_count_reg + 1'b1;
                end
            end
            default:
            begin
                // The unused request code does nothing and reports ok.
                status_next = STATUS_OK;
            end
        endcase

        if (exec_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            queue_head_reg  <= '0;
            queue_count_reg <= '0;
            fresh_next_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_fire)
            begin
                queue_head_reg  <= queue_head_next;
                queue_count_reg <= queue_count_next;
                fresh_next_reg  <= fresh_next_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg   <= func;
            handle_reg <= handle;
        end
        if (exec_fire)
        begin
            out_handle_reg <= out_handle_next;
            granted_reg    <= granted_next;
            status_reg     <= status_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign out_handle = out_handle_reg;
    assign granted    = granted_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

FILE: hdl/fra_map_store.sv
// Allocated-handle bitmap: one-bit synchronous memory with per-entry valid bits.
// Depends on fra_pkg. An entry never written since reset reads as zero.
`default_nettype none

module fra_map_store (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fra_pkg::map_req_t map_req,
    output logic                 rd_data
);
    import fra_pkg::*;

    logic                 map_mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] valid_reg;
    logic                 mem_q_reg;
    logic                 valid_q_reg;

    always_ff @(posedge clk)
    begin
        if (map_req.wr_en)
        begin
            map_mem[map_req.wr_addr] <= map_req.wr_data;
        end
        if (map_req.rd_en)
        begin
            mem_q_reg <= map_mem[map_req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end
        else
        begin
            if (map_req.wr_en)
            begin
                valid_reg[map_req.wr_addr] <= 1'b1;
            end
            if (map_req.rd_en)
            begin
                valid_q_reg <= valid_reg[map_req.rd_addr];
            end
        end
    end

    assign rd_data = mem_q_reg & valid_q_reg;

endmodule

`default_nettype wire

FILE: hdl/fra_queue_store.sv
// Free-handle FIFO storage: eight-bit synchronous memory, one write and one read port.
// Depends on fra_pkg. Contents are undefined until written.
`default_nettype none

module fra_queue_store (
    input  wire logic                clk,
    input  wire fra_pkg::queue_req_t queue_req,
    output fra_pkg::handle_t         rd_data
);
    import fra_pkg::*;

    handle_t queue_mem [MAP_DEPTH];
    handle_t rd_q_reg;

    always_ff @(posedge clk)
    begin
        if (queue_req.wr_en)
        begin
            queue_mem[queue_req.wr_addr] <= queue_req.wr_data;
        end
        if (queue_req.rd_en)
        begin
            rd_q_reg <= queue_mem[queue_req.rd_addr];
        end
    end

    assign rd_data = rd_q_reg;

endmodule

`default_nettype wire

FILE: dv/fra_grant_checker.sv
`timescale 1ns / 1ps
// Predictor and result checker for the slot-handle allocator.
// Depends on fra_pkg for handle, count, request and status types.

module fra_grant_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  handle,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [7:0]  out_handle,
    input  logic        granted,
    input  logic [1:0]  status,
    output int          check_failures,
    output int          owed_count
);
    import fra_pkg::*;

    typedef struct packed {
        handle_t hnd;
        logic    grant;
        status_t st;
    } grant_rsp_t;

    // Shadow of the allocator state.
    logic       slot_taken [0:MAP_DEPTH-1];
    handle_t    reuse_fifo [0:MAP_DEPTH-1];
    handle_t    reuse_head;
    count_t     reuse_count;
    count_t     fresh_next;

    grant_rsp_t owed_grants [$];
    int         fail_total;

    // Applies one request to the shadow state and returns the result it owes.
    function automatic grant_rsp_t grant_for_request(input logic [1:0] kind,
                                                     input handle_t hnd);
        grant_rsp_t rsp;
        rsp.hnd   = '0;
        rsp.grant = 1'b0;
        rsp.st    = STATUS_OK;
        if (kind == FUNC_ALLOC || kind == FUNC_TRY) begin
            if (reuse_count != 0) begin
                rsp.hnd     = reuse_fifo[reuse_head];
                rsp.grant   = 1'b1;
                reuse_head  = reuse_head + 1'b1;
                reuse_count = reuse_count - 1'b1;
                slot_taken[rsp.hnd] = 1'b1;
            end
            else if (kind == FUNC_TRY) begin
                rsp.st = STATUS_NONE;
            end
            else if (fresh_next >= CAPACITY) begin
                rsp.st = STATUS_EXHAUSTED;
            end
            else begin
                rsp.hnd    = handle_t'(fresh_next);
                rsp.grant  = 1'b1;
                fresh_next = fresh_next + 1'b1;
                slot_taken[rsp.hnd] = 1'b1;
            end
        end
        else if (kind == FUNC_FREE) begin
            if (!slot_taken[hnd]) begin
                rsp.st = STATUS_NOT_ALLOC;
            end
            else begin
                slot_taken[hnd] = 1'b0;
                reuse_fifo[handle_t'(reuse_head + reuse_count)] = hnd;
                reuse_count = reuse_count + 1'b1;
            end
        end
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        grant_rsp_t want;
        if (!rst_n) begin
            for (int i = 0; i < MAP_DEPTH; i++) begin
                slot_taken[i] = 1'b0;
            end
            reuse_head  = '0;
            reuse_count = '0;
            fresh_next  = '0;
            fail_total  = 0;
            owed_grants.delete();
            check_failures <= 0;
            owed_count     <= 0;
        end
        else begin
            if (req_valid && req_ready) begin
                owed_grants.push_back(grant_for_request(func, handle));
            end
            if (rsp_valid && rsp_ready) begin
                if (owed_grants.size() == 0) begin
                    $error("unexpected result: out_handle %0d granted %0d status %0d",
                           out_handle, granted, status);
                    fail_total++;
                end
                else begin
                    want = owed_grants.pop_front();
                    if (out_handle !== want.hnd) begin
                        $error("out_handle mismatch: expected %0d, got %0d",
                               want.hnd, out_handle);
                        fail_total++;
                    end
                    if (granted !== want.grant) begin
                        $error("granted mismatch: expected %0d, got %0d",
                               want.grant, granted);
                        fail_total++;
                    end
                    if (status !== want.st) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.st, status);
                        fail_total++;
                    end
                end
            end
            check_failures <= fail_total;
            owed_count     <= owed_grants.size();
        end
    end

endmodule

FILE: dv/tb_fifo_reuse_slot_allocator_unit.sv
`timescale 1ns / 1ps
// Top of the slot-handle allocator testbench: clock, reset, request stimulus,
// response back-pressure and verdict. Depends on fra_pkg and fra_grant_checker.

module tb_fifo_reuse_slot_allocator_unit;

    import fra_pkg::*;

    // The request selector has one code that the package leaves unnamed; the
    // block must treat it as a no-op that still returns a result.
    localparam logic [1:0] FUNC_NOP = 2'd3;

    // Cycles without any handshake on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;

    // Item counts for the two random phases.
    localparam int FILL_MAX_ITEMS = 700;
    localparam int FILL_EXTRA     = 20;
    localparam int MIX_ITEMS      = 180;

    // Response back-pressure patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic [1:0] func = FUNC_ALLOC;
    logic [7:0] handle = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic [7:0] out_handle;
    logic       granted;
    logic [1:0] status;

    int         check_failures;
    int         owed_count;

    // Handles seen granted and not yet freed by the stimulus. Frees drawn from
    // this list are well formed, so they reach the reuse FIFO.
    handle_t    live_handles [$];
    logic       exhausted_seen = 1'b0;

    int         burst_left = 8;
    int         idle_cycles = 0;

    rx_mode_t   rx_mode = RX_ALWAYS;
    int         rx_span = 0;
    logic [2:0] rx_tick = '0;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    fifo_reuse_slot_allocator_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .func       (func),
        .handle     (handle),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .out_handle (out_handle),
        .granted    (granted),
        .status     (status)
    );

    fra_grant_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .func           (func),
        .handle         (handle),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .out_handle     (out_handle),
        .granted        (granted),
        .status         (status),
        .check_failures (check_failures),
        .owed_count     (owed_count)
    );

    // The receiver picks a back-pressure pattern, holds it for a random span of
    // cycles, then picks again. Always-ready spans give stretches with no stalls;
    // the bursty pattern drives ready from bit two of a free-running tick.
    always @(negedge clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_span == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_span <= $urandom_range(20, 80);
        end
        else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= (rx_tick[1:0] == 2'd0);
            RX_BURSTY: rsp_ready <= rx_tick[2];
        endcase
    end

    // Track granted handles so that later frees can target live slots, and note
    // when the pool reports exhaustion so the fill phase knows it is done.
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            if (granted) begin
                live_handles.push_back(out_handle);
            end
            if (status == STATUS_EXHAUSTED) begin
                exhausted_seen <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Presents one request at a falling edge and holds it until accepted. The
    // sender works in bursts: valid stays high through a burst, and a random
    // gap (possibly none) follows each burst. Occasional long bursts keep the
    // request side busy.
    task automatic send_request(input logic [1:0] kind, input handle_t hnd);
        int gap;
        int idx;
        @(negedge clk);
        req_valid = 1'b1;
        func      = kind;
        handle    = hnd;
        // A freed handle is no longer a good target for well-formed frees.
        if (kind == FUNC_FREE) begin
            idx = -1;
            foreach (live_handles[i]) begin
                if (idx < 0 && live_handles[i] == hnd) begin
                    idx = i;
                end
            end
            if (idx >= 0) begin
                live_handles.delete(idx);
            end
        end
        @(posedge clk);
        while (!req_ready) begin
            @(posedge clk);
        end
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge clk);
                req_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            if ($urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(40, 80);
            end
            else begin
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Draws one request from the given percentages; whatever is left over goes
    // to the unused selector code. Every request carries a random handle, so the
    // bits of the handle field toggle even where the block ignores them.
    task automatic send_random(input int w_alloc, input int w_try,
                               input int w_free_live, input int w_free_any);
        int         roll;
        handle_t    hnd;
        logic [1:0] kind;
        roll = $urandom_range(0, 99);
        hnd  = handle_t'($urandom_range(0, 255));
        if (roll < w_alloc) begin
            kind = FUNC_ALLOC;
        end
        else if (roll < w_alloc + w_try) begin
            kind = FUNC_TRY;
        end
        else if (roll < w_alloc + w_try + w_free_live) begin
            kind = FUNC_FREE;
            if (live_handles.size() > 0) begin
                hnd = live_handles[$urandom_range(0, live_handles.size() - 1)];
            end
        end
        else if (roll < w_alloc + w_try + w_free_live + w_free_any) begin
            kind = FUNC_FREE;
        end
        else begin
            kind = FUNC_NOP;
        end
        send_request(kind, hnd);
    endtask

    // Lowers valid and holds off until every owed result has come back.
    task automatic drain_results();
        @(negedge clk);
        req_valid = 1'b0;
        while (owed_count != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        int fill_items;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Fresh handles start at zero and freed handles come
        // back oldest first, so the expected grants follow from the order below.
        send_request(FUNC_TRY,   8'hFF);  // empty pool: try grants nothing
        send_request(FUNC_FREE,  8'h00);  // never issued: refused
        send_request(FUNC_FREE,  8'hFF);  // top handle, never issued: refused
        send_request(FUNC_NOP,   8'hAA);  // unused selector
        send_request(FUNC_ALLOC, 8'h55);  // fresh 0, handle field ignored
        send_request(FUNC_ALLOC, 8'hFF);  // fresh 1
        send_request(FUNC_ALLOC, 8'h00);  // fresh 2
        send_request(FUNC_FREE,  8'h01);  // good free
        send_request(FUNC_FREE,  8'h01);  // double free: refused
        send_request(FUNC_FREE,  8'h00);  // good free
        send_request(FUNC_TRY,   8'h00);  // reuses 1, the oldest freed
        send_request(FUNC_ALLOC, 8'hFF);  // reuses 0
        send_request(FUNC_TRY,   8'h7F);  // reuse list empty: nothing, fresh ignored
        send_request(FUNC_ALLOC, 8'h80);  // fresh 3
        send_request(FUNC_FREE,  8'h02);
        send_request(FUNC_FREE,  8'h03);
        send_request(FUNC_FREE,  8'h00);
        send_request(FUNC_NOP,   8'h00);
        send_request(FUNC_ALLOC, 8'h00);  // reuses 2
        send_request(FUNC_ALLOC, 8'h00);  // reuses 3
        send_request(FUNC_TRY,   8'hFF);  // reuses 0
        send_request(FUNC_TRY,   8'hFF);  // empty again
        send_request(FUNC_FREE,  8'h04);  // at the fresh counter, never issued: refused

        // Let the block go fully idle before the random part.
        drain_results();

        // Fill phase: mostly allocations, so the fresh counter climbs to the
        // pool capacity and plain allocations start reporting exhaustion. A few
        // extra items after that hit the exhausted case repeatedly.
        fill_items = 0;
        while (!exhausted_seen && fill_items < FILL_MAX_ITEMS) begin
            send_random(85, 5, 5, 3);
            fill_items++;
        end
        repeat (FILL_EXTRA) send_random(70, 10, 10, 5);

        drain_results();

        // Mixed phase: the pool is at capacity, so most work cycles handles
        // through the reuse FIFO; noise frees and unused codes stay in the mix.
        repeat (MIX_ITEMS) send_random(25, 15, 40, 12);

        drain_results();
        repeat (8) @(posedge clk);

        if (check_failures == 0 && owed_count == 0) begin
            $display("ALL CHECKS PASSED");
        end
        else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/fra_pkg.sv
hdl/fra_map_store.sv
hdl/fra_queue_store.sv
hdl/fifo_reuse_slot_allocator_unit.sv
dv/fra_grant_checker.sv
dv/tb_fifo_reuse_slot_allocator_unit.sv
